@@ hw/rtl/haptic_detent_torque_unit_macros.svh @@
`ifndef HAPTIC_DETENT_TORQUE_UNIT_MACROS_SVH
`define HAPTIC_DETENT_TORQUE_UNIT_MACROS_SVH

// same-cycle implication on the port clock
`define HDT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication on the port clock
`define HDT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

@@ hw/rtl/hdt_pkg.sv @@
`timescale 1ns / 1ps
package hdt_pkg;

    localparam int ANGLE_W = 24;
    localparam int GAIN_W  = 10;
    localparam int WIDTH_W = 17;
    localparam int HYST_W  = 12;
    localparam int CUR_W   = 16;
    localparam int CNT_W   = 16;
    localparam int EVT_W   = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int STEP_W  = $clog2(ANGLE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ANGLE_W - 1);

    // spring scale: 2^14 / (1000 * 2^8) = 8 / 125
    localparam int MAG_W     = 15;
    localparam int PROD_W    = GAIN_W + WIDTH_W;
    localparam int XCAP_W    = 21;
    localparam logic [XCAP_W-1:0] X_CAP = XCAP_W'(2048000);
    localparam int RECIP_W   = 22;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(2147484);
    localparam int RECIP_SH  = 28;
    localparam int QPROD_W   = XCAP_W + RECIP_W;

    // snap threshold: |x| * 625 > gain * width * 18
    localparam int THR_W    = 32;
    localparam int EDGE_W   = 25;
    localparam logic [9:0] SNAP_SCALE = 10'd625;

    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_HYST  = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(10);
    localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(5120);
    localparam logic [HYST_W-1:0]  HYST_RST  = HYST_W'(77);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN = WIDTH_W'(2);

    localparam logic [EVT_W-1:0] EVT_NONE = 2'd0;
    localparam logic [EVT_W-1:0] EVT_CW   = 2'd1;
    localparam logic [EVT_W-1:0] EVT_CCW  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FOLD,
        ST_MUL1,
        ST_MUL2,
        ST_SELECT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fold;
        logic mul1;
        logic mul2;
        logic sel;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_busy;
    } status_t;

endpackage

@@ hw/rtl/hdt_regs.sv @@
`timescale 1ns / 1ps
module hdt_regs
    import hdt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output logic [GAIN_W-1:0]  gain,
    output logic [WIDTH_W-1:0] width,
    output logic [HYST_W-1:0]  hyst
);

    logic [GAIN_W-1:0]  gain_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [HYST_W-1:0]  hyst_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= GAIN_RST;
            width_reg <= WIDTH_RST;
            hyst_reg  <= HYST_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_GAIN:  gain_reg  <= pwdata[GAIN_W-1:0];
                REG_WIDTH: width_reg <= pwdata[WIDTH_W-1:0];
                REG_HYST:  hyst_reg  <= pwdata[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GAIN:  prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_reg};
            REG_WIDTH: prdata = {{(DATA_W-WIDTH_W){1'b0}}, width_reg};
            REG_HYST:  prdata = {{(DATA_W-HYST_W){1'b0}}, hyst_reg};
            default:   prdata = '0;
        endcase
    end

    assign gain  = gain_reg;
    assign width = width_reg;
    assign hyst  = hyst_reg;

endmodule

@@ hw/rtl/hdt_ctrl.sv @@
`timescale 1ns / 1ps
module hdt_ctrl
    import hdt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_SELECT;
            end
            ST_SELECT: begin
                cmd.sel    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/hdt_datapath.sv @@
`timescale 1ns / 1ps
module hdt_datapath
    import hdt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic [GAIN_W-1:0]         gain,
    input  logic [WIDTH_W-1:0]        width,
    input  logic [HYST_W-1:0]         hyst,
    input  logic signed [ANGLE_W-1:0] s_shaft_angle,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [CUR_W-1:0]   m_drive_current,
    output logic signed [CNT_W-1:0]   m_detent_count,
    output logic [EVT_W-1:0]          m_snap_event
);

    logic [ANGLE_W-1:0]      abs_reg;
    logic                    apos_reg;
    logic [WIDTH_W-1:0]      w_reg;
    logic [PROD_W-1:0]       gw_reg;
    logic [WIDTH_W-1:0]      rem_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [WIDTH_W-1:0]      d_reg;
    logic                    neg_reg;
    logic                    band_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic signed [CUR_W-1:0] cur_reg;
    logic signed [CUR_W-1:0] prev_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    m_valid_reg;
    logic signed [CUR_W-1:0] out_cur_reg;
    logic [CNT_W-1:0]        out_cnt_reg;
    logic [EVT_W-1:0]        out_evt_reg;

    logic [WIDTH_W-1:0]      w_eff;
    logic [ANGLE_W-1:0]      angle_abs;
    logic [WIDTH_W:0]        rem_sh;
    logic                    rem_ge;
    logic [WIDTH_W:0]        two_r;
    logic                    upper;
    logic signed [WIDTH_W+1:0] diff;
    logic [WIDTH_W:0]        diff_abs;
    logic [WIDTH_W:0]        band2;
    logic [PROD_W+2:0]       x_full;
    logic [XCAP_W-1:0]       x_cap;
    logic [QPROD_W-1:0]      q_prod;
    logic signed [CUR_W-1:0] spring;
    logic                    hold;
    logic [MAG_W-1:0]        prev_abs;
    logic [MAG_W-1:0]        cur_abs;
    logic [EDGE_W-1:0]       prev_scaled;
    logic [EDGE_W-1:0]       cur_scaled;
    logic                    edge_ok;
    logic                    snap_up;
    logic                    snap_dn;

    assign w_eff     = (width < WIDTH_MIN) ? WIDTH_MIN : width;
    assign angle_abs = s_shaft_angle[ANGLE_W-1] ? ANGLE_W'(-s_shaft_angle)
                                                : ANGLE_W'(s_shaft_angle);

    assign rem_sh = {rem_reg, abs_reg[ANGLE_W-1]};
    assign rem_ge = rem_sh >= {1'b0, w_reg};

    assign two_r    = {rem_reg, 1'b0};
    assign upper    = two_r >= {1'b0, w_reg};
    assign diff     = $signed({1'b0, two_r}) - $signed({2'b00, w_reg});
    assign diff_abs = diff[WIDTH_W+1] ? (WIDTH_W+1)'(-diff) : (WIDTH_W+1)'(diff);
    assign band2    = {{(WIDTH_W-HYST_W){1'b0}}, hyst, 1'b0};

    assign x_full = {prod_reg, 3'b000};
    assign x_cap  = (x_full >= {{(PROD_W+3-XCAP_W){1'b0}}, X_CAP}) ? X_CAP
                                                                   : x_full[XCAP_W-1:0];
    assign q_prod = {{RECIP_W{1'b0}}, x_cap} * {{XCAP_W{1'b0}}, RECIP};

    assign spring = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    assign hold   = band_reg && (neg_reg ? (prev_reg > 0) : (prev_reg < 0));

    assign prev_abs    = prev_reg[CUR_W-1] ? MAG_W'(-prev_reg) : MAG_W'(prev_reg);
    assign cur_abs     = cur_reg[CUR_W-1] ? MAG_W'(-cur_reg) : MAG_W'(cur_reg);
    assign prev_scaled = {10'b0, prev_abs} * {15'b0, SNAP_SCALE};
    assign cur_scaled  = {10'b0, cur_abs} * {15'b0, SNAP_SCALE};
    assign edge_ok = ({{(THR_W-EDGE_W){1'b0}}, prev_scaled} > thr_reg)
                  && ({{(THR_W-EDGE_W){1'b0}}, cur_scaled} > thr_reg);
    assign snap_dn = (prev_reg > 0) && (cur_reg < 0) && edge_ok;
    assign snap_up = (prev_reg < 0) && (cur_reg > 0) && edge_ok;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            abs_reg  <= angle_abs;
            apos_reg <= !s_shaft_angle[ANGLE_W-1] && (s_shaft_angle != '0);
            w_reg    <= w_eff;
            gw_reg   <= {{WIDTH_W{1'b0}}, gain} * {{GAIN_W{1'b0}}, w_eff};
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (cmd.div_step) begin
            abs_reg  <= {abs_reg[ANGLE_W-2:0], 1'b0};
            rem_reg  <= rem_ge ? WIDTH_W'(rem_sh - {1'b0, w_reg}) : rem_sh[WIDTH_W-1:0];
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.fold) begin
            d_reg    <= upper ? (w_reg - rem_reg) : rem_reg;
            neg_reg  <= (apos_reg == upper);
            band_reg <= diff_abs <= band2;
            thr_reg  <= {1'b0, gw_reg, 4'b0000} + {4'b0000, gw_reg, 1'b0};
        end
        if (cmd.mul1) begin
            prod_reg <= {{GAIN_W{1'b0}}, d_reg} * {{WIDTH_W{1'b0}}, gain};
        end
        if (cmd.mul2) begin
            mag_reg <= q_prod[RECIP_SH +: MAG_W];
        end
        if (cmd.sel) begin
            cur_reg <= hold ? prev_reg : spring;
        end
        if (cmd.emit) begin
            out_cur_reg <= cur_reg;
            if (snap_dn) begin
                out_cnt_reg <= count_reg - 1'b1;
                out_evt_reg <= EVT_CCW;
            end else if (snap_up) begin
                out_cnt_reg <= count_reg + 1'b1;
                out_evt_reg <= EVT_CW;
            end else begin
                out_cnt_reg <= count_reg;
                out_evt_reg <= EVT_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                prev_reg <= cur_reg;
                if (snap_dn) begin
                    count_reg <= count_reg - 1'b1;
                end else if (snap_up) begin
                    count_reg <= count_reg + 1'b1;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.div_last = (step_reg == LAST_STEP);
    assign status.out_busy = m_valid_reg & ~m_ready;

    assign m_valid         = m_valid_reg;
    assign m_drive_current = out_cur_reg;
    assign m_detent_count  = out_cnt_reg;
    assign m_snap_event    = out_evt_reg;

endmodule

@@ hw/rtl/haptic_detent_torque_unit.sv @@
`timescale 1ns / 1ps
// Each request runs the 24-step restoring divider that takes the angle modulo the
// detent width, then fold, MUL1, MUL2, select and emit; emit waits while the last result
// is still held, and no new request is taken until the current one has been emitted.
// A finished result waits in the output register while the next request is taken.
// Reset (aresetn low, synchronous): registers return to defaults, current and count clear.
module haptic_detent_torque_unit
    import hdt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [ANGLE_W-1:0] s_shaft_angle,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [CUR_W-1:0]   m_drive_current,
    output logic signed [CNT_W-1:0]   m_detent_count,
    output logic [EVT_W-1:0]          m_snap_event
);

    logic [GAIN_W-1:0]  gain;
    logic [WIDTH_W-1:0] width;
    logic [HYST_W-1:0]  hyst;
    cmd_t               cmd;
    status_t            status;

    hdt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gain    (gain),
        .width   (width),
        .hyst    (hyst)
    );

    hdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hdt_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .gain            (gain),
        .width           (width),
        .hyst            (hyst),
        .s_shaft_angle   (s_shaft_angle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_current (m_drive_current),
        .m_detent_count  (m_detent_count),
        .m_snap_event    (m_snap_event)
    );

endmodule

@@ hw/rtl/hdt_checker.sv @@
`timescale 1ns / 1ps
`include "haptic_detent_torque_unit_macros.svh"
module hdt_checker
    import hdt_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [CUR_W-1:0] m_drive_current,
    input logic [EVT_W-1:0]        m_snap_event
);

    `HDT_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_drive_current))
    `HDT_ASSERT_NXT(a_one_at_a_time, s_valid && s_ready, !s_ready)
    `HDT_ASSERT_IMP(a_cur_range, m_valid, (m_drive_current <= 16'sd16384) && (m_drive_current >= -16'sd16384))
    `HDT_ASSERT_IMP(a_cw_sign, m_valid && (m_snap_event == EVT_CW), m_drive_current > 16'sd0)
    `HDT_ASSERT_IMP(a_ccw_sign, m_valid && (m_snap_event == EVT_CCW), m_drive_current < 16'sd0)

endmodule

bind haptic_detent_torque_unit hdt_checker u_chk (.*);

@@ sim/haptic_detent_torque_checker.sv @@
`timescale 1ns / 1ps
module haptic_detent_torque_checker
    import hdt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic signed [ANGLE_W-1:0] s_shaft_angle,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [CUR_W-1:0]   m_drive_current,
    input  logic signed [CNT_W-1:0]   m_detent_count,
    input  logic [EVT_W-1:0]          m_snap_event,
    output int                        mismatches,
    output int                        outstanding
);

    localparam int ANGLE_FRAC   = 8;
    localparam int CURRENT_FRAC = 14;

    typedef struct packed {
        logic signed [CUR_W-1:0] current;
        logic signed [CNT_W-1:0] count;
        logic [EVT_W-1:0]        snap;
    } torque_t;

    torque_t            torque_q[$];
    logic [GAIN_W-1:0]  gain;
    logic [WIDTH_W-1:0] width;
    logic [HYST_W-1:0]  band;
    longint             held_current;
    logic [CNT_W-1:0]   snaps;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic longint magnitude(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint phase_current(input longint phase);
        longint g;
        longint q;
        g = gain;
        q = magnitude(phase) * g * (longint'(1) << CURRENT_FRAC)
            / (longint'(1000) << ANGLE_FRAC);
        return phase < 0 ? -q : q;
    endfunction

    function automatic torque_t predict_torque(input logic signed [ANGLE_W-1:0] angle);
        longint           a;
        longint           w;
        longint           g;
        longint           band2;
        longint           last;
        longint           p;
        longint           cur;
        longint           lim;
        longint           rhs;
        longint           scale;
        logic             in_band;
        logic             past_peak;
        logic [EVT_W-1:0] snap;
        torque_t          res;
        a = angle;
        w = width;
        if (w < 2) w = 2;
        g = gain;
        band2 = band;
        band2 = 2 * band2;
        last = held_current;
        p = a % w;
        lim = longint'(1) << CURRENT_FRAC;
        snap = EVT_NONE;

        if (a > 0) begin
            in_band = magnitude(2 * p - w) <= band2;
            if (2 * p < w)
                cur = (last < 0 && in_band) ? last : phase_current(p);
            else
                cur = (last > 0 && in_band) ? last : phase_current(p - w);
        end else begin
            in_band = magnitude(2 * p + w) <= band2;
            if (2 * p > -w)
                cur = (last > 0 && in_band) ? last : phase_current(p);
            else
                cur = (last < 0 && in_band) ? last : phase_current(w + p);
        end

        if (cur > lim)
            cur = lim;
        else if (cur < -lim)
            cur = -lim;

        // compare against 90% of the half-width spring current, cross-multiplied
        rhs = g * w * (longint'(1) << CURRENT_FRAC) * 9;
        scale = longint'(20000) << ANGLE_FRAC;
        past_peak = magnitude(last) * scale > rhs && magnitude(cur) * scale > rhs;
        if (last > 0 && cur < 0 && past_peak) begin
            snaps = snaps - 1'b1;
            snap = EVT_CCW;
        end else if (last < 0 && cur > 0 && past_peak) begin
            snaps = snaps + 1'b1;
            snap = EVT_CW;
        end

        held_current = cur;
        res.current = cur[CUR_W-1:0];
        res.count = snaps;
        res.snap = snap;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin : monitor
        torque_t want;
        if (!aresetn) begin
            gain = GAIN_RST;
            width = WIDTH_RST;
            band = HYST_RST;
            held_current = 0;
            snaps = '0;
            torque_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_GAIN:  gain  = pwdata[GAIN_W-1:0];
                    REG_WIDTH: width = pwdata[WIDTH_W-1:0];
                    REG_HYST:  band  = pwdata[HYST_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) torque_q.push_back(predict_torque(s_shaft_angle));
            if (m_valid && m_ready) begin
                if (torque_q.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending: current %0d",
                                              m_drive_current));
                end else begin
                    want = torque_q.pop_front();
                    if (m_drive_current !== want.current)
                        report_mismatch($sformatf("drive_current got %0d want %0d",
                                                  m_drive_current, want.current));
                    if (m_detent_count !== want.count)
                        report_mismatch($sformatf("detent_count got %0d want %0d",
                                                  m_detent_count, want.count));
                    if (m_snap_event !== want.snap)
                        report_mismatch($sformatf("snap_event got %0d want %0d",
                                                  m_snap_event, want.snap));
                end
            end
        end
        outstanding <= torque_q.size();
    end

endmodule

@@ sim/haptic_detent_torque_unit_tb.sv @@
`timescale 1ns / 1ps
module haptic_detent_torque_unit_tb;
    import hdt_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int LONG_HOLD       = 600;
    localparam int DRAIN_CYCLES    = 60;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 150;

    logic                      aclk;
    logic                      aresetn;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [ANGLE_W-1:0] s_shaft_angle;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [CUR_W-1:0]   m_drive_current;
    logic signed [CNT_W-1:0]   m_detent_count;
    logic [EVT_W-1:0]          m_snap_event;

    int     mismatch_count;
    int     results_owed;
    int     quiet_cycles = 0;
    logic   hold_off_req = 1'b0;
    longint knob_pos = 0;

    int directed_angles[23] = '{0, 1, -1, 2559, 2700, 2400, 2600, 2637, 2638, 2520,
                                2483, 2482, -2559, -2560, -2700, -2600, -2400,
                                8388607, -8388608, 5120, -5120, 7680, -7680};

    haptic_detent_torque_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_shaft_angle   (s_shaft_angle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_current (m_drive_current),
        .m_detent_count  (m_detent_count),
        .m_snap_event    (m_snap_event)
    );

    haptic_detent_torque_checker u_torque_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_shaft_angle   (s_shaft_angle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_current (m_drive_current),
        .m_detent_count  (m_detent_count),
        .m_snap_event    (m_snap_event),
        .mismatches      (mismatch_count),
        .outstanding     (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int         mode;
        int         span;
        logic [7:0] mask;
        forever begin
            if (hold_off_req) begin
                // hold results back long enough to back up the input side
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 120);
                mask = 8'($urandom_range(1, 255));
                for (int i = 0; i < span; i++) begin
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= ($urandom_range(0, 3) != 0);
                        2: m_ready <= mask[i % 8];
                        default: m_ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_angle(input logic signed [ANGLE_W-1:0] angle);
        s_valid <= 1'b1;
        s_shaft_angle <= angle;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_input(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    // mix of raw noise, a turning knob, and angles near half-width and detent centers
    function automatic logic signed [ANGLE_W-1:0] pick_angle(input longint w, input longint hy);
        longint k;
        longint a;
        int     sel;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, 8388607 / w);
        if (sel < 15) begin
            a = longint'($urandom);
        end else if (sel < 55) begin
            knob_pos += ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(0, w / 3 + 2));
            if (knob_pos > 8388607)
                knob_pos -= 16777216;
            else if (knob_pos < -8388608)
                knob_pos += 16777216;
            a = knob_pos;
        end else if (sel < 85) begin
            a = k * w + w / 2 + longint'($urandom_range(0, 2 * hy + 6)) - hy - 3;
            if ($urandom_range(0, 1)) a = -a;
        end else begin
            a = k * w + longint'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 1)) a = -a;
        end
        return a[ANGLE_W-1:0];
    endfunction

    initial begin
        int     gain_set;
        int     width_set;
        int     hyst_set;
        int     burst_left;
        longint w_eff;

        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_shaft_angle <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_angles[i]) push_angle(ANGLE_W'(directed_angles[i]));
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin gain_set = 10;   width_set = 5120;   hyst_set = 77;   end
                1: begin gain_set = 1023; width_set = 92160;  hyst_set = 2560; end
                2: begin gain_set = 0;    width_set = 2;      hyst_set = 0;    end
                3: begin gain_set = 37;   width_set = 0;      hyst_set = 4095; end
                4: begin gain_set = 500;  width_set = 1;      hyst_set = 1;    end
                5: begin gain_set = 1;    width_set = 131071; hyst_set = 4095; end
                default: begin
                    gain_set = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(1, 120);
                    width_set = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                            : $urandom_range(64, 12000);
                    hyst_set = $urandom_range(0, 1) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, width_set / 8);
                    hyst_set = hyst_set % 4096;
                end
            endcase
            write_reg(REG_GAIN, gain_set);
            write_reg(REG_WIDTH, width_set);
            write_reg(REG_HYST, hyst_set);
            w_eff = (width_set < 2) ? 2 : width_set;
            knob_pos = longint'($urandom_range(0, 16777215)) - 8388608;
            if (ph == 1) hold_off_req = 1'b1;

            burst_left = $urandom_range(1, 20);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                push_angle(pick_angle(w_eff, hyst_set));
                burst_left--;
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(40, 120);
                    end else begin
                        pause_input($urandom_range(1, 15));
                        burst_left = $urandom_range(1, 20);
                    end
                end
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
